// File: sv/qrrs_pkg.sv
// Shared types, constants and GF(2^8) arithmetic for the QR Reed-Solomon encoder.
// No dependencies; imported by qrrs_cell and qr_reed_solomon_ecc_encoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package qrrs_pkg;

    // Field reduction polynomial 0x11d without the x^8 term.
    localparam logic [7:0] GF_POLY_LOW    = 8'h1d;
    localparam logic [7:0] GF_ALPHA       = 8'h02;
    localparam logic [7:0] GF_ONE         = 8'h01;
    localparam int         CFG_W          = 5;
    localparam int         RESET_ECC_LEN  = 10;

    // One input transfer: a data codeword and the end-of-block mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } qrrs_in_t;

    // One output transfer: a check codeword and the final-byte mark.
    typedef struct packed {
        logic [7:0] ecc_byte;
        logic       ecc_last;
    } qrrs_out_t;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic init;     // load the starting generator and clear the remainder
        logic derive;   // multiply the generator by (x - root)
        logic absorb;   // fold one data byte into the remainder
        logic capture;  // copy the updated remainder to the output row, clear it
        logic drain;    // shift the output row one cell toward the head
    } qrrs_cell_ctrl_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_DERIVE = 3'b010,
        ST_RUN    = 3'b100
    } qrrs_state_t;

    // GF(2^8) multiply, bit-serial over the bits of b, highest first.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int k = 7; k >= 0; k--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? GF_POLY_LOW : 8'h00);
            if (b[k])
            begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// File: sv/qr_reed_solomon_ecc_encoder_unit.sv
// Top level of the QR Reed-Solomon check byte encoder over GF(2^8), poly 0x11d.
// Depends on qrrs_pkg and on a chain of MAX_ECC_BYTES qrrs_cell instances.
//
//   Channel | Signals                          | Carries
//   --------+----------------------------------+-----------------------------------
//   data    | data_valid, data_stall, data_item | data_byte, block_end (in)
//   ecc     | ecc_valid, ecc_stall, ecc_item    | ecc_byte, ecc_last (out)
//   cfg     | cfg_we, cfg_wdata                 | ecc_length, write only
//
// One data byte is taken per cycle while data_stall is low; every cell updates
// its remainder byte at once. A block end copies the remainder to the output row,
// which drains its n bytes while the next block streams in; a further block end
// waits until the row is free. After reset or a cfg write the generator is built
// by a load step, then one root per cycle, with the data channel stalled meanwhile.
// Reset is asynchronous, active low, and selects ten check bytes.
`timescale 1ns / 1ps
`default_nettype none

module qr_reed_solomon_ecc_encoder_unit
    import qrrs_pkg::*;
#(
    parameter int MAX_ECC_BYTES = 30
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              data_valid,
    output logic                   data_stall,
    input  wire qrrs_in_t          data_item,
    output logic                   ecc_valid,
    input  wire logic              ecc_stall,
    output qrrs_out_t              ecc_item
);

    localparam int CNT_W = $clog2(MAX_ECC_BYTES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CNT_W-1:0] RESET_LEN =
        CNT_W'((RESET_ECC_LEN > MAX_ECC_BYTES) ? MAX_ECC_BYTES : RESET_ECC_LEN);

    qrrs_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [7:0]        root_reg, root_next;
    logic [CNT_W-1:0]  cfg_len;

    qrrs_cell_ctrl_t   ctrl;
    logic              data_xfer;
    logic              ecc_xfer;
    logic              out_busy;
    logic              out_freeing;
    logic [7:0]        factor;

    logic [7:0] gen_w  [MAX_ECC_BYTES];
    logic [7:0] rem_w  [MAX_ECC_BYTES];
    logic [7:0] hold_w [MAX_ECC_BYTES];

    // Written length, saturated into 1 .. MAX_ECC_BYTES.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_len = CNT_W'(1);
        end
        else if (CMP_W'(cfg_wdata) > CMP_W'(MAX_ECC_BYTES))
        begin
            cfg_len = CNT_W'(MAX_ECC_BYTES);
        end
        else
        begin
            cfg_len = CNT_W'(cfg_wdata);
        end
    end

    // Handshakes. A block end waits while the output row still holds bytes,
    // unless its final byte leaves in this same cycle.
    assign out_busy    = (out_cnt_reg != '0);
    assign ecc_valid   = out_busy;
    assign ecc_xfer    = ecc_valid && !ecc_stall;
    assign out_freeing = ecc_xfer && (out_cnt_reg == CNT_W'(1));
    assign data_stall  = (state_reg != ST_RUN)
                       || (data_item.block_end && out_busy && !out_freeing);
    assign data_xfer   = data_valid && !data_stall;

    assign factor = data_item.data_byte ^ rem_w[0];

    // Commands for the chain.
    always_comb
    begin
        ctrl.init    = (state_reg == ST_LOAD);
        ctrl.derive  = (state_reg == ST_DERIVE);
        ctrl.absorb  = data_xfer;
        ctrl.capture = data_xfer && data_item.block_end;
        ctrl.drain   = ecc_xfer;
    end

    // Generator setup sequencer and configuration.
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_LOAD:
            begin
                state_next = ST_DERIVE;
                step_next  = '0;
                root_next  = GF_ONE;
            end
            ST_DERIVE:
            begin
                root_next = gf_mul(root_reg, GF_ALPHA);
                step_next = step_reg + CNT_W'(1);
                if (step_reg == len_reg - CNT_W'(1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (cfg_we)
        begin
            len_next   = cfg_len;
            state_next = ST_LOAD;
        end
    end

    // Count of check bytes left in the output row.
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (ctrl.capture)
        begin
            out_cnt_next = len_reg;
        end
        else if (ecc_xfer)
        begin
            out_cnt_next = out_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            len_reg     <= RESET_LEN;
            step_reg    <= '0;
            out_cnt_reg <= '0;
            root_reg    <= GF_ONE;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            step_reg    <= step_next;
            out_cnt_reg <= out_cnt_next;
            root_reg    <= root_next;
        end
    end

    // The cell chain; cell 0 holds the highest order byte. The last cell is fed zeros.
    for (genvar i = 0; i < MAX_ECC_BYTES; i++)
    begin : g_cell
        logic [7:0] gen_up;
        logic [7:0] rem_up;
        logic [7:0] hold_up;
        logic       is_top;

        if (i + 1 < MAX_ECC_BYTES)
        begin : g_mid
            assign gen_up  = gen_w[i+1];
            assign rem_up  = rem_w[i+1];
            assign hold_up = hold_w[i+1];
        end
        else
        begin : g_end
            assign gen_up  = 8'h00;
            assign rem_up  = 8'h00;
            assign hold_up = 8'h00;
        end

        assign is_top = (len_reg == CNT_W'(i + 1));

        qrrs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .is_top  (is_top),
            .root    (root_reg),
            .factor  (factor),
            .gen_up  (gen_up),
            .rem_up  (rem_up),
            .hold_up (hold_up),
            .gen     (gen_w[i]),
            .rem     (rem_w[i]),
            .hold    (hold_w[i])
        );
    end

    // The head of the output row is the current check byte.
    assign ecc_item.ecc_byte = hold_w[0];
    assign ecc_item.ecc_last = (out_cnt_reg == CNT_W'(1));

endmodule

`default_nettype wire

// File: sv/qrrs_cell.sv
// One cell of the encoder chain: a generator coefficient, a remainder byte
// and an output byte. Depends on qrrs_pkg for the command struct and gf_mul.
`timescale 1ns / 1ps
`default_nettype none

module qrrs_cell
    import qrrs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire qrrs_cell_ctrl_t  ctrl,
    input  wire logic             is_top,
    input  wire logic [7:0]       root,
    input  wire logic [7:0]       factor,
    input  wire logic [7:0]       gen_up,
    input  wire logic [7:0]       rem_up,
    input  wire logic [7:0]       hold_up,
    output logic [7:0]            gen,
    output logic [7:0]            rem,
    output logic [7:0]            hold
);

    logic [7:0] gen_reg, gen_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] rem_absorbed;

    // Remainder after one data byte: the upper neighbor shifted in plus g * factor.
    assign rem_absorbed = rem_up ^ gf_mul(gen_reg, factor);

    // Generator coefficient.
    always_comb
    begin
        gen_next = gen_reg;
        if (ctrl.init)
        begin
            gen_next = is_top ? GF_ONE : 8'h00;
        end
        else if (ctrl.derive)
        begin
            gen_next = gf_mul(gen_reg, root) ^ gen_up;
        end
    end

    // Remainder byte; cleared on init and once the block's check bytes have been captured.
    always_comb
    begin
        rem_next = rem_reg;
        if (ctrl.init)
        begin
            rem_next = 8'h00;
        end
        else if (ctrl.absorb)
        begin
            rem_next = ctrl.capture ? 8'h00 : rem_absorbed;
        end
    end

    // Output byte; a capture takes priority over the last shift of the old block.
    always_comb
    begin
        hold_next = hold_reg;
        if (ctrl.capture)
        begin
            hold_next = rem_absorbed;
        end
        else if (ctrl.drain)
        begin
            hold_next = hold_up;
        end
    end

    // Remainder and generator must start clean; the output row is payload only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            gen_reg <= gen_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign gen  = gen_reg;
    assign rem  = rem_reg;
    assign hold = hold_reg;

endmodule

`default_nettype wire
